// ===== hw/rtl/rbc_pkg.sv =====
// Shared types and constants for the range-or-bitset run chooser.
// No dependencies; imported by rbc_classify, rbc_tracker and the top level.
package rbc_pkg;

    // Width of the codepoint fields on the ports.
    localparam int OUT_BITS      = 21;
    // Varint carries 7 payload bits per byte (radix 128).
    localparam int VARINT_SHIFT  = 7;
    // Bitmap bytes hold 8 codepoints.
    localparam int BYTE_SHIFT    = 3;

    typedef enum logic
    {
        CMD_ADD = 1'b0,
        CMD_END = 1'b1
    } rbc_cmd_t;

    typedef struct packed
    {
        logic [OUT_BITS-1:0] run_start;
        logic [OUT_BITS-1:0] run_end;
        logic                as_range;
        logic                end_of_set;
    } rbc_result_t;

endpackage

// ===== hw/rtl/rbc_classify.sv =====
// Range-versus-bitmap cost comparison for one closed run.
// Depends on rbc_pkg (shift constants).
module rbc_classify
    import rbc_pkg::*;
#(
    parameter int CODE_BITS = 21
)
(
    input  logic [CODE_BITS-1:0] run_first,
    input  logic [CODE_BITS-1:0] run_last,
    input  logic [CODE_BITS-1:0] emitted_last,
    input  logic                 prior_valid,
    input  logic [CODE_BITS-1:0] prior_last,
    input  logic                 has_next,
    input  logic [CODE_BITS-1:0] next_first,
    output logic                 as_range
);

    localparam int GROUPS = (CODE_BITS + VARINT_SHIFT - 1) / VARINT_SHIFT;
    localparam int VW     = $clog2(GROUPS + 1);
    localparam int CW     = CODE_BITS + 1;

    // Bytes needed to hold v as a varint, minimum one.
    function automatic logic [VW-1:0] varint_bytes(input logic [CODE_BITS-1:0] v);
        logic [VW-1:0] n;
        n = VW'(1);
        for (int k = 1; k < GROUPS; k++)
        begin
            if ((v >> (VARINT_SHIFT * k)) != '0)
            begin
                n = n + VW'(1);
            end
        end
        return n;
    endfunction

    logic [CODE_BITS-1:0] gap;
    logic [CODE_BITS-1:0] span;
    logic [1:0]           shared;
    logic [CW-1:0]        range_cost;
    logic [CW-1:0]        bitmap_bytes;

    always_comb
    begin
        gap  = (run_first >= emitted_last) ? (run_first - emitted_last) : '0;
        span = run_last - run_first;

        // Bytes shared with the neighbor runs come off the bitmap cost;
        // moved to the left side so the compare stays unsigned.
        shared = 2'd0;
        if (prior_valid && ((prior_last >> BYTE_SHIFT) == (run_first >> BYTE_SHIFT)))
        begin
            shared = shared + 2'd1;
        end
        if (has_next && ((next_first >> BYTE_SHIFT) == (run_last >> BYTE_SHIFT)))
        begin
            shared = shared + 2'd1;
        end

        range_cost   = CW'(varint_bytes(gap)) + CW'(varint_bytes(span)) + CW'(shared);
        // ceil((span + 1) / 8) == span / 8 + 1
        bitmap_bytes = CW'(span >> BYTE_SHIFT) + CW'(1);

        as_range = (run_first != run_last) && (range_cost <= bitmap_bytes);
    end

endmodule

// ===== hw/rtl/rbc_tracker.sv =====
// Run tracking state: joins ascending codepoints into runs, decides when
// a run closes and builds its result. Depends on rbc_pkg and rbc_classify.
module rbc_tracker
    import rbc_pkg::*;
#(
    parameter int CODE_BITS = 21
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  rbc_cmd_t            item_cmd,
    input  logic [OUT_BITS-1:0] item_cp,
    input  logic                advance,
    output logic                emit,
    output rbc_result_t         result
);

    logic                 run_open_reg,     run_open_next;
    logic [CODE_BITS-1:0] run_first_reg,    run_first_next;
    logic [CODE_BITS-1:0] run_last_reg,     run_last_next;
    logic                 prior_valid_reg,  prior_valid_next;
    logic [CODE_BITS-1:0] prior_last_reg,   prior_last_next;
    logic [CODE_BITS-1:0] emitted_last_reg, emitted_last_next;

    logic [CODE_BITS-1:0] cp;
    logic                 is_end;
    logic                 has_next;
    logic                 as_range;

    assign cp     = CODE_BITS'(item_cp);
    assign is_end = (item_cmd == CMD_END);
    // a codepoint that closes a run is the next run's first value;
    // the end item has no next run
    assign has_next = !is_end;

    rbc_classify #(
        .CODE_BITS (CODE_BITS)
    ) u_classify (
        .run_first    (run_first_reg),
        .run_last     (run_last_reg),
        .emitted_last (emitted_last_reg),
        .prior_valid  (prior_valid_reg),
        .prior_last   (prior_last_reg),
        .has_next     (has_next),
        .next_first   (cp),
        .as_range     (as_range)
    );

    always_comb
    begin
        run_open_next     = run_open_reg;
        run_first_next    = run_first_reg;
        run_last_next     = run_last_reg;
        prior_valid_next  = prior_valid_reg;
        prior_last_next   = prior_last_reg;
        emitted_last_next = emitted_last_reg;
        emit              = 1'b0;

        if (item_valid)
        begin
            if (is_end)
            begin
                emit              = run_open_reg;
                run_open_next     = 1'b0;
                run_first_next    = '0;
                run_last_next     = '0;
                prior_valid_next  = 1'b0;
                prior_last_next   = '0;
                emitted_last_next = '0;
            end
            else if (!run_open_reg)
            begin
                run_open_next  = 1'b1;
                run_first_next = cp;
                run_last_next  = cp;
            end
            else if (cp <= run_last_reg)
            begin
                // out of order: dropped
            end
            else if ({1'b0, cp} == ({1'b0, run_last_reg} + (CODE_BITS + 1)'(1)))
            begin
                run_last_next = cp;
            end
            else
            begin
                emit             = 1'b1;
                run_first_next   = cp;
                run_last_next    = cp;
                prior_valid_next = 1'b1;
                prior_last_next  = run_last_reg;
                if (as_range)
                begin
                    emitted_last_next = run_last_reg;
                end
            end
        end
    end

    always_comb
    begin
        result.run_start  = OUT_BITS'(run_first_reg);
        result.run_end    = OUT_BITS'(run_last_reg);
        result.as_range   = as_range;
        result.end_of_set = is_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg     <= 1'b0;
            run_first_reg    <= '0;
            run_last_reg     <= '0;
            prior_valid_reg  <= 1'b0;
            prior_last_reg   <= '0;
            emitted_last_reg <= '0;
        end
        else if (advance)
        begin
            run_open_reg     <= run_open_next;
            run_first_reg    <= run_first_next;
            run_last_reg     <= run_last_next;
            prior_valid_reg  <= prior_valid_next;
            prior_last_reg   <= prior_last_next;
            emitted_last_reg <= emitted_last_next;
        end
    end

endmodule

// ===== hw/rtl/range_or_bitset_chooser.sv =====
// Top level of the range-or-bitset run chooser: input register, run
// tracker and result register. Depends on rbc_pkg and rbc_tracker.

// Codepoints of a set arrive one per item in ascending order (tuser = 0);
// an item with tuser = 1 ends the set. Consecutive codepoints are joined
// into runs, and every run that closes comes out as one item carrying its
// first and last codepoint, tuser = 1 if it holds more than one codepoint
// and costs no more as an explicit range (varint gap + varint span) than
// as bitmap bytes, and tlast on the run flushed by the end item. A
// codepoint not above the previous one is dropped. The block takes one
// item per cycle while no result is held back by a full result register;
// a result passes the input register, then the result register, before
// it is presented. The pace is set by the update of the run state, which
// holds an item in the input register only while a result it must produce
// finds the result register still full.
module range_or_bitset_chooser
    import rbc_pkg::*;
#(
    parameter int CODE_BITS = 21
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] codepoint, [23:21] zero
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [20:0] run_start, [41:21] run_end, [47:42] zero
    output logic [0:0]  m_axis_tuser,   // [0] as_range
    output logic        m_axis_tlast    // end_of_set
);

    // input register
    logic                in_valid_reg, in_valid_next;
    rbc_cmd_t            in_cmd_reg;
    logic [OUT_BITS-1:0] in_cp_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    rbc_result_t         out_reg;

    logic                emit;
    rbc_result_t         result;
    logic                out_free;
    logic                fire;

    rbc_tracker #(
        .CODE_BITS (CODE_BITS)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_cmd   (in_cmd_reg),
        .item_cp    (in_cp_reg),
        .advance    (fire),
        .emit       (emit),
        .result     (result)
    );

    // An item with no result always moves on; one with a result needs
    // the result register free (empty or being drained this cycle).
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && (!emit || out_free);
    assign s_axis_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end

        out_valid_next = out_valid_reg;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg <= rbc_cmd_t'(s_axis_tuser[0]);
            in_cp_reg  <= s_axis_tdata[OUT_BITS-1:0];
        end
        if (fire && emit)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.run_end, out_reg.run_start};
    assign m_axis_tuser  = out_reg.as_range;
    assign m_axis_tlast  = out_reg.end_of_set;

`ifndef SYNTHESIS
    // a range always spans more than one codepoint
    a_range_multi: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[20:0] != m_axis_tdata[41:21]))
        else $error("range result with a single codepoint");

    // a run never ends below its start
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[20:0] <= m_axis_tdata[41:21]))
        else $error("run end below run start");

    // a new result only follows a tracker step that produced one
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(fire && emit))
        else $error("result register loaded without a closed run");
`endif

endmodule

// ===== bench/range_or_bitset_chooser_tb.sv =====
// Self-checking bench for range_or_bitset_chooser: streams codepoint sets in,
// predicts every classified run and checks each result item in order.
// Depends on rbc_pkg and the range_or_bitset_chooser RTL.
`timescale 1ns / 1ps

module range_or_bitset_chooser_tb;
    import rbc_pkg::*;

    localparam int    CP_MAX     = 1114111;
    localparam int    ITEM_GOAL  = 750;
    localparam int    IDLE_PCT   = 21;
    localparam int    SHOW_LIMIT = 10;
    // idle-free stretch, counted in accepted input items
    localparam int    CALM_FROM  = 320;
    localparam int    CALM_TO    = 480;

    typedef struct packed
    {
        rbc_cmd_t            cmd;
        logic [OUT_BITS-1:0] cp;
    } set_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // [20:0] codepoint, [23:21] zero
    logic [0:0]  s_axis_tuser;     // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;     // [20:0] run_start, [41:21] run_end, [47:42] zero
    logic [0:0]  m_axis_tuser;     // [0] as_range
    logic        m_axis_tlast;     // end_of_set

    range_or_bitset_chooser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    set_item_t   pending_items[$];   // items still to be sent
    rbc_result_t runs_due[$];        // classified runs not yet seen at the output

    int items_taken;
    int runs_seen;
    int ranges_seen;
    int set_ends_seen;
    int errors;
    logic in_fire_q;

    // Shadow of the run tracker.
    logic                run_open_s;
    logic [OUT_BITS-1:0] run_first_s;
    logic [OUT_BITS-1:0] run_last_s;
    logic                prior_valid_s;
    logic [OUT_BITS-1:0] prior_last_s;
    logic [OUT_BITS-1:0] range_tail_s;   // end of the last run sent as a range

    // Generator's view of the set being built.
    int   gen_last;
    int   gen_counted;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("timeout: %0d items left to send, %0d runs outstanding",
                 pending_items.size(), runs_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    wire calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int varint_len(int unsigned v);
        int n;
        n = 1;
        while (v >= 128)
        begin
            v = v >> 7;
            n++;
        end
        return n;
    endfunction

    // Classify the open run and queue the result item it produces.
    task automatic close_open_run(input logic has_next, input logic [OUT_BITS-1:0] next_first,
                                  input logic last_of_set);
        rbc_result_t r;
        int unsigned gap;
        int unsigned span;
        int          range_cost;
        int          bitmap_cost;
        logic        pick_range;
        pick_range = 1'b0;
        if (run_first_s != run_last_s)
        begin
            gap  = (run_first_s >= range_tail_s) ? run_first_s - range_tail_s : 0;
            span = run_last_s - run_first_s;
            range_cost  = varint_len(gap) + varint_len(span);
            bitmap_cost = (span + 1 + 7) / 8;
            // bytes shared with a neighbor run are already paid for
            if (prior_valid_s && (prior_last_s >> BYTE_SHIFT) == (run_first_s >> BYTE_SHIFT))
                bitmap_cost--;
            if (has_next && (next_first >> BYTE_SHIFT) == (run_last_s >> BYTE_SHIFT))
                bitmap_cost--;
            pick_range = (range_cost <= bitmap_cost);
        end
        r.run_start  = run_first_s;
        r.run_end    = run_last_s;
        r.as_range   = pick_range;
        r.end_of_set = last_of_set;
        runs_due = {runs_due, r};
        if (pick_range)
            range_tail_s = run_last_s;
        prior_valid_s = 1'b1;
        prior_last_s  = run_last_s;
    endtask

    task automatic clear_tracker();
        run_open_s    = 1'b0;
        run_first_s   = '0;
        run_last_s    = '0;
        prior_valid_s = 1'b0;
        prior_last_s  = '0;
        range_tail_s  = '0;
    endtask

    task automatic track_item(input set_item_t it);
        if (it.cmd == CMD_END)
        begin
            if (run_open_s)
                close_open_run(1'b0, '0, 1'b1);
            clear_tracker();
        end
        else if (!run_open_s)
        begin
            run_open_s  = 1'b1;
            run_first_s = it.cp;
            run_last_s  = it.cp;
        end
        else if (it.cp <= run_last_s)
        begin
            // not ascending: dropped
        end
        else if ({1'b0, it.cp} == {1'b0, run_last_s} + 1)
            run_last_s = it.cp;
        else
        begin
            close_open_run(1'b1, it.cp, 1'b0);
            run_first_s = it.cp;
            run_last_s  = it.cp;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic send_cp(input int cp);
        set_item_t it;
        it.cmd = CMD_ADD;
        it.cp  = cp[OUT_BITS-1:0];
        pending_items = {pending_items, it};
        gen_last = cp;
        gen_counted++;
    endtask

    // a codepoint at or below the last one; the block drops it
    task automatic send_stale(input int cp);
        set_item_t it;
        it.cmd = CMD_ADD;
        it.cp  = cp[OUT_BITS-1:0];
        pending_items = {pending_items, it};
    endtask

    task automatic send_end(input logic counted);
        set_item_t it;
        it.cmd = CMD_END;
        it.cp  = OUT_BITS'($urandom_range(0, CP_MAX));   // ignored by the block
        pending_items = {pending_items, it};
        if (counted)
            gen_counted++;
    endtask

    task automatic build_directed();
        // end with nothing open
        send_end(1'b1);
        // single-value run, then a two-value run squeezed between neighbors
        // in the same bitmap bytes (bitmap cost goes negative)
        send_cp(0);
        send_stale(0);
        send_cp(2);
        send_cp(3);
        send_cp(5);
        send_stale(4);
        // nine values: range cost ties bitmap cost, range wins
        for (int v = 16; v <= 24; v++)
            send_cp(v);
        // top of the code space, flushed by the end item
        send_cp(CP_MAX - 1);
        send_cp(CP_MAX);
        send_end(1'b1);
        // lone high codepoint flushed by end
        send_cp(1048576);
        send_end(1'b1);
    endtask

    task automatic build_random_set();
        int start;
        int len;
        int step;
        int nxt;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            start = CP_MAX - $urandom_range(0, 400);
        else if (pick == 1)
            start = $urandom_range(0, 20);
        else if (pick < 5)
            start = $urandom_range(0, 5000);
        else
            start = $urandom_range(0, CP_MAX);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
        send_cp(start);
        for (int i = 1; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                step = 1;
            else if (pick < 80)
                step = $urandom_range(2, 9);
            else if (pick < 92)
                step = $urandom_range(10, 300);
            else
                step = $urandom_range(300, 70000);
            nxt = gen_last + step;
            if (nxt > CP_MAX)
                break;
            if ($urandom_range(0, 99) < 5)
                send_stale($urandom_range(0, gen_last));
            send_cp(nxt);
        end
        send_end(1'b1);
        // stray end with no run open
        if ($urandom_range(0, 99) < 5)
            send_end(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Input driver: changes at the falling edge, holds an offered item
    // until it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_fire_q <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            track_item(pending_items[0]);
            pending_items.pop_front();
            items_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !in_fire_q)
        begin
            // offered item not yet taken: hold it
        end
        else if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {3'b000, pending_items[0].cp};
            s_axis_tuser  <= pending_items[0].cmd;
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, in-order compare at the rising edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        rbc_result_t want;
        logic [OUT_BITS-1:0] got_start;
        logic [OUT_BITS-1:0] got_end;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_start = m_axis_tdata[20:0];
            got_end   = m_axis_tdata[41:21];
            runs_seen++;
            if (m_axis_tuser[0])
                ranges_seen++;
            if (m_axis_tlast)
                set_ends_seen++;
            if (runs_due.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t: result %0h..%0h range=%0b last=%0b with none expected",
                             $realtime, got_start, got_end, m_axis_tuser[0], m_axis_tlast);
            end
            else
            begin
                want = runs_due.pop_front();
                if (got_start != want.run_start || got_end != want.run_end
                    || m_axis_tuser[0] != want.as_range || m_axis_tlast != want.end_of_set)
                begin
                    errors++;
                    if (errors <= SHOW_LIMIT)
                        $display("%0t: want %0h..%0h range=%0b last=%0b, got %0h..%0h range=%0b last=%0b",
                                 $realtime, want.run_start, want.run_end, want.as_range,
                                 want.end_of_set, got_start, got_end, m_axis_tuser[0],
                                 m_axis_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset once, drain, report
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        in_fire_q     = 1'b0;
        items_taken   = 0;
        runs_seen     = 0;
        ranges_seen   = 0;
        set_ends_seen = 0;
        errors        = 0;
        gen_last      = 0;
        gen_counted   = 0;
        clear_tracker();

        build_directed();
        while (gen_counted < ITEM_GOAL)
            build_random_set();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || runs_due.size() != 0)
            @(posedge clk);
        // two-stage pipeline: keep clocking so that any stray result is still caught
        repeat (8) @(posedge clk);

        if (runs_due.size() != 0)
        begin
            $display("%0d expected runs never arrived", runs_due.size());
            errors += runs_due.size();
        end

        $display("sent %0d items; checked %0d runs (%0d as range, %0d closing a set)",
                 items_taken, runs_seen, ranges_seen, set_ends_seen);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_classify.sv
hw/rtl/rbc_tracker.sv
hw/rtl/range_or_bitset_chooser.sv
bench/range_or_bitset_chooser_tb.sv
